// ----- rtl/lis_pkg.sv -----
// Shared types and constants for the longest increasing subsequence block.
`default_nettype none
package lis_pkg;

  localparam int unsigned VAL_W            = 32;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned LINK_W           = 7;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  localparam logic [LINK_W-1:0] NO_LINK = 7'h7F;
  localparam logic [VAL_W-1:0]  VAL_LO  = 32'h8000_0000;
  localparam logic [VAL_W-1:0]  VAL_HI  = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_SHOW
  } lis_state_e;

  // passed from each cell to the next one up
  typedef struct packed {
    logic              le;
    logic              eq;
    logic [LINK_W-1:0] link;
  } lis_nbr_t;

  // per-cell report to the top level
  typedef struct packed {
    logic              wr;
    logic              ext;
    logic              top;
    logic [LINK_W-1:0] link;
  } lis_cell_out_t;

endpackage
`default_nettype wire

// ----- rtl/lis_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lis_cell.sv -----
// One tail slot: holds the smallest tail value and its position for one length.
`default_nettype none
module lis_cell
  import lis_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 take_i,
  input  wire logic [VAL_W-1:0]     value_i,
  input  wire logic [POS_W-1:0]     wpos_i,
  input  wire logic [CNT_W-1:0]     best_i,
  input  wire lis_nbr_t             prev_i,
  output lis_nbr_t                  next_o,
  output lis_cell_out_t             out_o
);

  logic [VAL_W-1:0] tail_q;
  logic [POS_W-1:0] pos_q;
  logic             valid;
  logic             valid_up;
  logic             le;
  logic             wr;

  assign valid    = best_i > CNT_W'(IDX);
  assign valid_up = best_i > CNT_W'(IDX + 1);
  assign le       = valid && ($signed(tail_q) <= $signed(value_i));

  // insertion point: everything below is < value, this slot is > value or empty
  assign wr = take_i && prev_i.le && !le && !prev_i.eq;

  assign next_o.le   = le;
  assign next_o.eq   = valid && (tail_q == value_i);
  assign next_o.link = LINK_W'(pos_q);

  assign out_o.wr   = wr;
  assign out_o.ext  = wr && !valid;
  assign out_o.top  = wr && !valid_up;
  assign out_o.link = wr ? prev_i.link : '0;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      tail_q <= value_i;
      pos_q  <= wpos_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/longest_increasing_subsequence.sv -----
// Top level: longest strictly increasing subsequence over a stream of signed words.
//
// Input channel (in_valid_i/in_ready_o) takes one signed 32-bit value per word,
// final_element_i flags the last word of a sequence. A non-final word is taken
// without leaving the idle state; a row of MAX_ELEMENTS tail cells compares it
// against every stored tail at once and the matching cell updates itself.
// After the final word the input channel is held off. The predecessor links
// are walked back from the top tail, one link RAM read per cycle, into a chain
// RAM. The chain is then played out in ascending position order, one output
// word per chain RAM read: each word is read in ST_READ and then waits in the
// output register in ST_SHOW as long as out_ready_i is low. The last word
// carries last_of_run_o.
// A sequence with no usable value yields one word: position 0, length 1.
// Values beyond MAX_ELEMENTS in one sequence are ignored.
// Reset clears the word count, best length and state; no clearing pass is needed,
// the block takes a word in the first cycle after reset.
`default_nettype none
module longest_increasing_subsequence
  import lis_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic              final_element_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [POS_W-1:0]  position_o,
  output logic      [LEN_W-1:0]  subsequence_length_o,
  output logic                   last_of_run_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);

  lis_state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [POS_W-1:0]  top_pos_q, top_pos_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic [ADDR_W-1:0] e_q, e_d;
  logic              first_q, first_d;

  logic              accept;
  logic              room;
  logic              take;
  logic [CNT_W-1:0]  best_inc;
  logic [CNT_W-1:0]  best_m1;
  logic [POS_W-1:0]  wpos;
  logic [POS_W-1:0]  cur;
  logic              empty;
  logic              last;

  logic              any_wr;
  logic              any_ext;
  logic              any_top;
  logic [LINK_W-1:0] wlink;

  logic [LINK_W-1:0] lnk_rdata;
  logic [POS_W-1:0]  chn_rdata;

  lis_nbr_t          nbr [MAX_ELEMENTS+1];
  lis_cell_out_t     co  [MAX_ELEMENTS];

  assign accept = in_valid_i && in_ready_o;
  assign room   = count_q < CNT_W'(MAX_ELEMENTS);
  assign take   = accept && room && (value_i != VAL_LO) && (value_i != VAL_HI);
  assign wpos   = POS_W'(count_q[ADDR_W-1:0]);

  assign nbr[0] = '{le: 1'b1, eq: 1'b0, link: NO_LINK};

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    lis_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .take_i  (take),
      .value_i (value_i),
      .wpos_i  (wpos),
      .best_i  (best_q),
      .prev_i  (nbr[i]),
      .next_o  (nbr[i+1]),
      .out_o   (co[i])
    );
  end

  always_comb begin
    any_wr  = 1'b0;
    any_ext = 1'b0;
    any_top = 1'b0;
    wlink   = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      any_wr  = any_wr  | co[i].wr;
      any_ext = any_ext | co[i].ext;
      any_top = any_top | co[i].top;
      wlink   = wlink   | co[i].link;
    end
  end

  assign best_inc = best_q + CNT_W'(any_ext);
  assign best_m1  = best_inc - CNT_W'(1);

  assign cur   = first_q ? top_pos_q : lnk_rdata[POS_W-1:0];
  assign empty = best_q == '0;
  assign last  = empty || ((CNT_W'(e_q) + CNT_W'(1)) == best_q);

  lis_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (any_wr),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (wlink),
    .re_i    (state_q == ST_WALK),
    .raddr_i (cur[ADDR_W-1:0]),
    .rdata_o (lnk_rdata)
  );

  lis_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_WALK) && !empty),
    .waddr_i (k_q),
    .wdata_i (cur),
    .re_i    (state_q == ST_READ),
    .raddr_i (e_q),
    .rdata_o (chn_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && final_element_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (empty) begin
          state_d = ST_SHOW;
        end else if (k_q == '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (out_ready_i) state_d = last ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o           = 1'b0;
    out_valid_o          = 1'b0;
    position_o           = empty ? '0 : chn_rdata;
    subsequence_length_o = empty ? LEN_W'(1) : LEN_W'(best_q);
    last_of_run_o        = last;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_SHOW: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    count_d   = count_q;
    best_d    = best_q;
    top_pos_d = top_pos_q;
    k_d       = k_q;
    e_d       = e_q;
    first_d   = first_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          best_d = best_inc;
          if (any_top) top_pos_d = wpos;
          if (final_element_i) begin
            count_d = '0;
            k_d     = best_m1[ADDR_W-1:0];
            first_d = 1'b1;
          end else if (room) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_WALK: begin
        first_d = 1'b0;
        k_d     = k_q - ADDR_W'(1);
        e_d     = '0;
      end
      ST_READ: ;
      ST_SHOW: begin
        if (out_ready_i) begin
          if (last) begin
            best_d = '0;
          end else begin
            e_d = e_q + ADDR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      best_q  <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      best_q  <= best_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_pos_q <= top_pos_d;
    k_q       <= k_d;
    e_q       <= e_d;
  end

endmodule
`default_nettype wire
